// ===== sv/stpd_pkg.sv =====
// Types, constants and helper functions shared by the pixel difference block.
`timescale 1ns / 1ps

package stpd_pkg;

    localparam int DIM_W   = 13;
    localparam int POS_W   = DIM_W + 1;
    localparam int SHIFT_W = 6;
    localparam int OFF_W   = SHIFT_W + 1;
    localparam int TOL_W   = 10;
    localparam int PIX_W   = 24;
    localparam int CH_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_TOLERANCE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_TOLERANCE = 2'd3;

    localparam logic [CH_W-1:0] MARK_BLUE  = 8'd0;
    localparam logic [CH_W-1:0] MARK_GREEN = 8'd128;
    localparam logic [CH_W-1:0] MARK_RED   = 8'd225;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [SHIFT_W-1:0] shift;
        logic [TOL_W-1:0]   tol;
    } stpd_cfg_t;

    typedef struct packed {
        logic            mismatch;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic            out_of_range;
    } stpd_res_t;

    function automatic logic [CH_W:0] abs_diff(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
        logic [CH_W:0] d;
        begin
            d = (a > b) ? {1'b0, a - b} : {1'b0, b - a};
            abs_diff = d;
        end
    endfunction

    function automatic logic close_enough(input pixel_t p, input pixel_t q,
                                          input logic [TOL_W-1:0] tol);
        logic [TOL_W-1:0] s;
        begin
            s = TOL_W'(abs_diff(p[7:0], q[7:0]))
              + TOL_W'(abs_diff(p[15:8], q[15:8]))
              + TOL_W'(abs_diff(p[23:16], q[23:16]));
            close_enough = (s <= tol);
        end
    endfunction

endpackage

// ===== sv/stpd_if.sv =====
// Handshake interfaces for pixel items, results and register writes.
`timescale 1ns / 1ps

interface stpd_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] x_coord;
    logic [7:0] y_coord;
    logic [7:0] base_blue;
    logic [7:0] base_green;
    logic [7:0] base_red;
    logic [7:0] sample_blue;
    logic [7:0] sample_green;
    logic [7:0] sample_red;

    modport source (output valid, action, x_coord, y_coord, base_blue, base_green, base_red,
                    sample_blue, sample_green, sample_red, input ready);
    modport sink (input valid, action, x_coord, y_coord, base_blue, base_green, base_red,
                  sample_blue, sample_green, sample_red, output ready);
endinterface

interface stpd_out_if;
    logic       valid;
    logic       ready;
    logic       mismatch;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       out_of_range;

    modport source (output valid, mismatch, out_blue, out_green, out_red, out_of_range,
                    input ready);
    modport sink (input valid, mismatch, out_blue, out_green, out_red, out_of_range,
                  output ready);
endinterface

interface stpd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [9:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/stpd_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module stpd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/stpd_cfg_regs.sv =====
// Configuration register file with saturation of size and shift settings.
`timescale 1ns / 1ps

module stpd_cfg_regs #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_SHIFT  = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    stpd_cfg_if.sink            cfg,
    output stpd_pkg::stpd_cfg_t cfg_sat
);
    import stpd_pkg::*;

    logic [8:0]       width_reg;
    logic [8:0]       height_reg;
    logic [3:0]       shift_reg;
    logic [TOL_W-1:0] tol_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
            shift_reg  <= 4'd1;
            tol_reg    <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_IMAGE_WIDTH:     width_reg  <= cfg.data[8:0];
                REG_IMAGE_HEIGHT:    height_reg <= cfg.data[8:0];
                REG_SHIFT_TOLERANCE: shift_reg  <= cfg.data[3:0];
                REG_COLOR_TOLERANCE: tol_reg    <= cfg.data;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        cfg_sat.width  = (32'(width_reg) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : DIM_W'(width_reg);
        cfg_sat.height = (32'(height_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT)
                                                        : DIM_W'(height_reg);
        cfg_sat.shift  = (32'(shift_reg) > MAX_SHIFT) ? SHIFT_W'(MAX_SHIFT)
                                                      : SHIFT_W'(shift_reg);
        cfg_sat.tol    = tol_reg;
    end

endmodule

// ===== sv/shift_tolerant_pixel_diff.sv =====
// Top level: base and sample image stores with a shift- and colour-tolerant pixel check.
// A load inside the configured size writes the base and sample pixel at (x,y) in both RAMs at once;
// the block is ready for the next transaction in the following cycle. A check outside the
// configured size goes straight to the finish state with out_of_range set. A check inside reads
// the direct base and sample pixels and answers from them when they match or the shift is zero.
// Otherwise it walks the 2t by 2t search window through the single read port of the sample RAM,
// one pixel per cycle, stopping at the first match. Each result waits in an output register,
// and a new transaction is taken while it waits. The RAMs need no clearing after reset.
`timescale 1ns / 1ps

module shift_tolerant_pixel_diff #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_SHIFT  = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    stpd_in_if.sink    pix_in,
    stpd_out_if.source res_out,
    stpd_cfg_if.sink   cfg
);
    import stpd_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIRECT = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    function automatic logic [AW-1:0] pix_addr(input logic [DIM_W-1:0] yy,
                                               input logic [DIM_W-1:0] xx);
        pix_addr = AW'(32'(yy) * MAX_WIDTH + 32'(xx));
    endfunction

    stpd_cfg_t cfg_sat;

    logic [2:0]       state_reg, state_next;
    logic [7:0]       x_reg, x_next;
    logic [7:0]       y_reg, y_next;
    pixel_t           bp_reg, bp_next;
    logic [OFF_W-1:0] di_reg, di_next;
    logic [OFF_W-1:0] dj_reg, dj_next;
    logic             pend_reg, pend_next;
    stpd_res_t        res_reg, res_next;
    stpd_res_t        out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic             accept;
    logic             in_image;
    logic [AW-1:0]    in_addr;
    logic [AW-1:0]    win_addr;
    logic [AW-1:0]    sample_raddr;
    logic             ram_we;
    pixel_t           base_wdata;
    pixel_t           sample_wdata;
    pixel_t           base_rdata;
    pixel_t           sample_rdata;
    logic [OFF_W-1:0] t_ext;
    logic [OFF_W-1:0] last_off;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             win_ok;
    logic             direct_ok;
    logic             scan_hit;

    stpd_cfg_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_SHIFT  (MAX_SHIFT)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_sat (cfg_sat)
    );

    assign pix_in.ready = (state_reg == S_IDLE);
    assign accept       = pix_in.valid && pix_in.ready;
    assign in_image     = (DIM_W'(pix_in.x_coord) < cfg_sat.width)
                       && (DIM_W'(pix_in.y_coord) < cfg_sat.height);
    assign in_addr      = pix_addr(DIM_W'(pix_in.y_coord), DIM_W'(pix_in.x_coord));
    assign ram_we       = accept && (pix_in.action == ACT_LOAD) && in_image;
    assign base_wdata   = {pix_in.base_red, pix_in.base_green, pix_in.base_blue};
    assign sample_wdata = {pix_in.sample_red, pix_in.sample_green, pix_in.sample_blue};

    assign t_ext    = OFF_W'(cfg_sat.shift);
    assign last_off = OFF_W'({t_ext, 1'b0} - 1'b1);
    assign pos_x    = POS_W'(x_reg) - POS_W'(t_ext) + POS_W'(di_reg);
    assign pos_y    = POS_W'(y_reg) - POS_W'(t_ext) + POS_W'(dj_reg);
    assign win_ok   = !pos_x[POS_W-1] && !pos_y[POS_W-1]
                   && (pos_x[DIM_W-1:0] < cfg_sat.width)
                   && (pos_y[DIM_W-1:0] < cfg_sat.height);
    assign win_addr = pix_addr(pos_y[DIM_W-1:0], pos_x[DIM_W-1:0]);

    assign sample_raddr = (state_reg == S_SCAN) ? win_addr : in_addr;
    assign direct_ok    = close_enough(base_rdata, sample_rdata, cfg_sat.tol);
    assign scan_hit     = pend_reg && close_enough(bp_reg, sample_rdata, cfg_sat.tol);

    stpd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_base_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_addr),
        .wdata (base_wdata),
        .raddr (in_addr),
        .rdata (base_rdata)
    );

    stpd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_sample_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_addr),
        .wdata (sample_wdata),
        .raddr (sample_raddr),
        .rdata (sample_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        bp_next        = bp_reg;
        di_next        = di_reg;
        dj_next        = dj_reg;
        pend_next      = 1'b0;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !res_out.ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (pix_in.action == ACT_CHECK))
                begin
                    x_next = pix_in.x_coord;
                    y_next = pix_in.y_coord;
                    if (in_image)
                    begin
                        state_next = S_DIRECT;
                    end
                    else
                    begin
                        res_next   = '{mismatch: 1'b0, blue: '0, green: '0, red: '0,
                                       out_of_range: 1'b1};
                        state_next = S_FINISH;
                    end
                end
            end
            S_DIRECT:
            begin
                bp_next  = base_rdata;
                di_next  = '0;
                dj_next  = '0;
                res_next = '{mismatch: 1'b0, blue: sample_rdata[7:0],
                             green: sample_rdata[15:8], red: sample_rdata[23:16],
                             out_of_range: 1'b0};
                if (direct_ok)
                begin
                    state_next = S_FINISH;
                end
                else if (t_ext == '0)
                begin
                    res_next   = '{mismatch: 1'b1, blue: MARK_BLUE, green: MARK_GREEN,
                                   red: MARK_RED, out_of_range: 1'b0};
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    pend_next = win_ok;
                    if (dj_reg == last_off)
                    begin
                        dj_next = '0;
                        if (di_reg == last_off)
                        begin
                            state_next = S_DRAIN;
                        end
                        else
                        begin
                            di_next = di_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        dj_next = dj_reg + 1'b1;
                    end
                end
            end
            S_DRAIN:
            begin
                if (!scan_hit)
                begin
                    res_next = '{mismatch: 1'b1, blue: MARK_BLUE, green: MARK_GREEN,
                                 red: MARK_RED, out_of_range: 1'b0};
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || res_out.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        bp_reg  <= bp_next;
        di_reg  <= di_next;
        dj_reg  <= dj_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign res_out.valid        = out_valid_reg;
    assign res_out.mismatch     = out_reg.mismatch;
    assign res_out.out_blue     = out_reg.blue;
    assign res_out.out_green    = out_reg.green;
    assign res_out.out_red      = out_reg.red;
    assign res_out.out_of_range = out_reg.out_of_range;

`ifndef SYNTHESIS
    a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IDLE))
        else $error("image write outside idle state");

    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == S_SCAN || state_reg == S_DRAIN))
        else $error("window read pending outside search");

    a_scan_needs_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (t_ext != '0))
        else $error("search running with empty window");

    a_finish_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && (!out_valid_reg || res_out.ready))
        |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("finished result not moved to output register");
`endif

endmodule
